### rtl/tsc_pkg.sv
// Shared types and constants for the touch sample calibrator.
// Used by tsc_ctrl, tsc_dp and touch_sample_calibrator_unit; no dependencies.
`default_nettype none

package tsc_pkg;

  localparam int unsigned SmpW     = 12;            // sample and register width
  localparam int unsigned ProdW    = 2 * SmpW;      // diff * resolution
  localparam int unsigned PxW      = 9;             // point_x width
  localparam int unsigned PyW      = 8;             // point_y width
  localparam int unsigned WordW    = 16;            // raw controller word width
  localparam int unsigned SmpLsb   = 3;             // sample sits in bits 14..3
  localparam int unsigned RegIdxW  = 2;

  localparam logic [SmpW-1:0] HorRes = SmpW'(320);
  localparam logic [SmpW-1:0] VerRes = SmpW'(240);

  localparam logic [SmpW-1:0] MinReset = SmpW'(200);
  localparam logic [SmpW-1:0] MaxReset = SmpW'(3800);

  // one quotient bit per step; quotient fits in SmpW bits
  localparam int unsigned DivSteps = SmpW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  typedef enum logic [RegIdxW-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } tsc_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_STORE = 5'b01000,
    ST_OUT   = 5'b10000
  } tsc_state_e;

  typedef struct packed {
    logic load;      // capture an input transfer
    logic mul;       // sample, diff, span and product for current axis
    logic step;      // one restoring division step
    logic store;     // finish current axis into the held point
    logic out_load;  // load output register
    logic axis;      // 0 = x, 1 = y
  } tsc_cmd_t;

  typedef struct packed {
    logic pen;       // pen-down flag of the captured item
  } tsc_stat_t;

endpackage

`default_nettype wire

### rtl/touch_sample_calibrator_unit.sv
// Top level of the touch sample calibrator: sequencer plus datapath.
// Depends on tsc_pkg, tsc_ctrl and tsc_dp.
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i / in_stall_o pen_down_i, raw_x_word_i, raw_y_word_i
//   out      out        out_valid_o / out_stall_i point_x_o, point_y_o, pressed_o
//
// Pen-down poll: the next transfer waits for the output register load, which follows the
//   shared 12-step restoring divider run once per axis (1 multiply, 12 steps, 1 store each).
// Pen-up poll: the held point is sent again.
// A new poll is taken while the previous result waits in the output register.
// Reset restores calibration defaults (200 / 3800) and clears the held point.
`default_nettype none

module touch_sample_calibrator_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tsc_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  wire logic [tsc_pkg::SmpW-1:0]     cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         pen_down_i,
  input  wire logic [tsc_pkg::WordW-1:0]    raw_x_word_i,
  input  wire logic [tsc_pkg::WordW-1:0]    raw_y_word_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [tsc_pkg::PxW-1:0]           point_x_o,
  output logic [tsc_pkg::PyW-1:0]           point_y_o,
  output logic                              pressed_o
);

  tsc_pkg::tsc_cmd_t  cmd;
  tsc_pkg::tsc_stat_t stat;

  tsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tsc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pen_down_i   (pen_down_i),
    .raw_x_word_i (raw_x_word_i),
    .raw_y_word_i (raw_y_word_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .pressed_o    (pressed_o)
  );

endmodule

`default_nettype wire

### rtl/tsc_ctrl.sv
// Sequencer for the touch sample calibrator: handshakes and datapath commands.
// Depends on tsc_pkg.
`default_nettype none

module tsc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire tsc_pkg::tsc_stat_t stat_i,
  output tsc_pkg::tsc_cmd_t     cmd_o
);

  tsc_pkg::tsc_state_e state_q, state_d;
  logic                      axis_q, axis_d;
  logic [tsc_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic                      in_xfer, out_xfer, out_free;

  assign in_stall_o  = (state_q != tsc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      tsc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d     = 1'b0;
          // pen up skips calibration, the held point goes out again
          state_d    = stat_i.pen ? tsc_pkg::ST_MUL : tsc_pkg::ST_OUT;
        end
      end
      tsc_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = tsc_pkg::ST_DIV;
      end
      tsc_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == tsc_pkg::CntW'(tsc_pkg::DivSteps - 1)) begin
          state_d = tsc_pkg::ST_STORE;
        end
      end
      tsc_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = tsc_pkg::ST_MUL;
        end else begin
          state_d = tsc_pkg::ST_OUT;
        end
      end
      tsc_pkg::ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = tsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsc_pkg::ST_IDLE;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsc_pkg::ST_DIV) |-> (cnt_q < tsc_pkg::CntW'(tsc_pkg::DivSteps)))
    else $error("division step count out of range");

  a_pen_down_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && stat_i.pen) |=> (state_q == tsc_pkg::ST_MUL && !axis_q))
    else $error("pen-down item did not start on x axis");

  a_pen_up_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !stat_i.pen) |=> (state_q == tsc_pkg::ST_OUT))
    else $error("pen-up item did not go straight to output");

  a_y_after_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsc_pkg::ST_STORE && !axis_q) |=> (state_q == tsc_pkg::ST_MUL && axis_q))
    else $error("y axis did not follow x axis");

endmodule

`default_nettype wire

### rtl/tsc_dp.sv
// Datapath of the touch sample calibrator: calibration registers, multiplier,
// shared restoring divider, held point and output register. Depends on tsc_pkg.
`default_nettype none

module tsc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tsc_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  wire logic [tsc_pkg::SmpW-1:0]      cfg_wdata_i,
  input  wire logic                          pen_down_i,
  input  wire logic [tsc_pkg::WordW-1:0]     raw_x_word_i,
  input  wire logic [tsc_pkg::WordW-1:0]     raw_y_word_i,
  input  wire tsc_pkg::tsc_cmd_t             cmd_i,
  output tsc_pkg::tsc_stat_t                 stat_o,
  output logic [tsc_pkg::PxW-1:0]            point_x_o,
  output logic [tsc_pkg::PyW-1:0]            point_y_o,
  output logic                               pressed_o
);

  localparam int unsigned SmpW  = tsc_pkg::SmpW;
  localparam int unsigned ProdW = tsc_pkg::ProdW;

  logic [SmpW-1:0]  x_min_q, x_max_q, y_min_q, y_max_q;
  logic             pen_q;
  logic [tsc_pkg::WordW-1:0] wx_q, wy_q;
  logic [ProdW-1:0] acc_q, acc_d;
  logic [SmpW-1:0]  span_q;
  logic             zero_q, sat_q;
  logic [tsc_pkg::PxW-1:0] held_x_q;
  logic [tsc_pkg::PyW-1:0] held_y_q;
  logic [tsc_pkg::PxW-1:0] px_q;
  logic [tsc_pkg::PyW-1:0] py_q;
  logic             pressed_q;

  logic [tsc_pkg::WordW-1:0] word;
  logic [SmpW-1:0]  lo, hi, res, sample, diff, span, scaled, coord;
  logic [ProdW-1:0] prod;
  logic [SmpW:0]    trial, trial_sub;
  logic             ge;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= tsc_pkg::MinReset;
      x_max_q <= tsc_pkg::MaxReset;
      y_min_q <= tsc_pkg::MinReset;
      y_max_q <= tsc_pkg::MaxReset;
    end else if (cfg_we_i) begin
      unique case (tsc_pkg::tsc_reg_e'(cfg_idx_i))
        tsc_pkg::REG_X_MIN: x_min_q <= cfg_wdata_i;
        tsc_pkg::REG_X_MAX: x_max_q <= cfg_wdata_i;
        tsc_pkg::REG_Y_MIN: y_min_q <= cfg_wdata_i;
        tsc_pkg::REG_Y_MAX: y_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign stat_o.pen = cmd_i.load ? pen_down_i : pen_q;

  // axis select
  assign word   = cmd_i.axis ? wy_q    : wx_q;
  assign lo     = cmd_i.axis ? y_min_q : x_min_q;
  assign hi     = cmd_i.axis ? y_max_q : x_max_q;
  assign res    = cmd_i.axis ? tsc_pkg::VerRes : tsc_pkg::HorRes;
  assign sample = word[tsc_pkg::SmpLsb +: SmpW];
  assign diff   = (sample > lo) ? (sample - lo) : '0;
  assign span   = hi - lo;
  assign prod   = ProdW'(diff) * ProdW'(res);

  // restoring step: top half is the partial remainder, low half shifts in
  // dividend bits and collects quotient bits
  assign trial     = {acc_q[ProdW-1:SmpW], acc_q[SmpW-1]};
  assign trial_sub = trial - {1'b0, span_q};
  assign ge        = (trial >= {1'b0, span_q});

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul) begin
      acc_d = prod;
    end else if (cmd_i.step) begin
      acc_d = {(ge ? trial_sub[SmpW-1:0] : trial[SmpW-1:0]), acc_q[SmpW-2:0], ge};
    end
  end

  // span not positive gives zero; diff >= span means the quotient is at least res: saturate
  always_comb begin
    priority if (zero_q) begin
      scaled = '0;
    end else if (sat_q) begin
      scaled = res;
    end else begin
      scaled = acc_q[SmpW-1:0];
    end
  end
  assign coord = res - scaled;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pen_q <= pen_down_i;
      wx_q  <= raw_x_word_i;
      wy_q  <= raw_y_word_i;
    end
    if (cmd_i.mul) begin
      span_q <= span;
      zero_q <= !(hi > lo);
      sat_q  <= (diff >= span);
    end
    acc_q <= acc_d;
    if (cmd_i.out_load) begin
      px_q      <= held_x_q;
      py_q      <= held_y_q;
      pressed_q <= pen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q <= '0;
      held_y_q <= '0;
    end else if (cmd_i.store) begin
      if (cmd_i.axis) begin
        held_y_q <= coord[tsc_pkg::PyW-1:0];
      end else begin
        held_x_q <= coord[tsc_pkg::PxW-1:0];
      end
    end
  end

  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign pressed_o = pressed_q;

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for touch_sample_calibrator_unit: random polls under bursty input and output stalls,
// with a built-in calibration predictor and in-order result checking.
// Depends on rtl/tsc_pkg.sv and the calibrator RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SmpW    = tsc_pkg::SmpW;
  localparam int unsigned PxW     = tsc_pkg::PxW;
  localparam int unsigned PyW     = tsc_pkg::PyW;
  localparam int unsigned WordW   = tsc_pkg::WordW;
  localparam int unsigned SmpLsb  = tsc_pkg::SmpLsb;
  localparam int unsigned RegIdxW = tsc_pkg::RegIdxW;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 240;

  typedef struct packed {
    logic             pen;
    logic [WordW-1:0] wx;
    logic [WordW-1:0] wy;
  } poll_t;

  typedef struct packed {
    logic [PxW-1:0] x;
    logic [PyW-1:0] y;
    logic           pressed;
  } point_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i   = '0;
  logic [SmpW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                pen_down_i  = 1'b0;
  logic [WordW-1:0]    raw_x_word_i = '0;
  logic [WordW-1:0]    raw_y_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [PxW-1:0]      point_x_o;
  logic [PyW-1:0]      point_y_o;
  logic                pressed_o;

  touch_sample_calibrator_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pen_down_i   (pen_down_i),
    .raw_x_word_i (raw_x_word_i),
    .raw_y_word_i (raw_y_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .pressed_o    (pressed_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state: calibration registers and the held point
  logic [SmpW-1:0] cal_reg [4];
  logic [PxW-1:0]  held_x = '0;
  logic [PyW-1:0]  held_y = '0;

  poll_t  polls_to_send[$];
  point_t due_points[$];

  int unsigned errors         = 0;
  int unsigned points_checked = 0;
  int unsigned polls_taken    = 0;
  int unsigned cycles         = 0;
  logic        idling_on      = 1'b0;
  logic        in_taken       = 1'b0;
  int unsigned gap_left       = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_left     = 0;

  // sample minus min (floored), scaled by res over the span, saturated, then mirrored
  function automatic int unsigned map_axis(logic [WordW-1:0] word, logic [SmpW-1:0] lo,
                                           logic [SmpW-1:0] hi, int unsigned res);
    int unsigned smp;
    int unsigned diff;
    int unsigned scaled;
    smp    = 32'(word[SmpLsb+SmpW-1:SmpLsb]);
    diff   = (smp > lo) ? smp - lo : 0;
    scaled = 0;
    if (hi > lo) begin
      scaled = (diff * res) / (hi - lo);
      if (scaled > res) scaled = res;
    end
    return res - scaled;
  endfunction

  function automatic point_t predict_poll(poll_t p);
    point_t r;
    if (p.pen) begin
      held_x = PxW'(map_axis(p.wx, cal_reg[tsc_pkg::REG_X_MIN], cal_reg[tsc_pkg::REG_X_MAX],
                             32'(tsc_pkg::HorRes)));
      held_y = PyW'(map_axis(p.wy, cal_reg[tsc_pkg::REG_Y_MIN], cal_reg[tsc_pkg::REG_Y_MAX],
                             32'(tsc_pkg::VerRes)));
    end
    r.x       = held_x;
    r.y       = held_y;
    r.pressed = p.pen;
    return r;
  endfunction

  // sample placed in bits 14..3, random junk in the ignored bits
  function automatic logic [WordW-1:0] word_of(logic [SmpW-1:0] smp);
    logic [3:0] junk;
    junk = 4'($urandom);
    return {junk[3], smp, junk[2:0]};
  endfunction

  function automatic logic [SmpW-1:0] near_span(logic [SmpW-1:0] a, logic [SmpW-1:0] b);
    int lo;
    int hi;
    lo = ((a < b) ? int'(a) : int'(b)) - 16;
    hi = ((a < b) ? int'(b) : int'(a)) + 16;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    return SmpW'($urandom_range(lo, hi));
  endfunction

  task automatic push_poll(logic pen, logic [WordW-1:0] wx, logic [WordW-1:0] wy);
    poll_t p;
    p.pen = pen;
    p.wx  = wx;
    p.wy  = wy;
    polls_to_send.push_back(p);
  endtask

  task automatic write_reg(tsc_pkg::tsc_reg_e idx, logic [SmpW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    cal_reg[idx] = val;
  endtask

  task automatic set_calibration(logic [SmpW-1:0] xlo, logic [SmpW-1:0] xhi,
                                 logic [SmpW-1:0] ylo, logic [SmpW-1:0] yhi);
    write_reg(tsc_pkg::REG_X_MIN, xlo);
    write_reg(tsc_pkg::REG_X_MAX, xhi);
    write_reg(tsc_pkg::REG_Y_MIN, ylo);
    write_reg(tsc_pkg::REG_Y_MAX, yhi);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (polls_to_send.size() != 0 || in_valid_i || due_points.size() != 0)
      @(negedge clk_i);
  endtask

  // poll driver: bursts of transfers, separated by random gaps when idling is on
  always @(negedge clk_i) begin : drive_polls
    poll_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (polls_to_send.size() != 0) begin
        nxt = polls_to_send.pop_front();
        in_valid_i   <= 1'b1;
        pen_down_i   <= nxt.pen;
        raw_x_word_i <= nxt.wx;
        raw_y_word_i <= nxt.wy;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          if (idling_on && $urandom_range(0, 3) != 0) gap_left <= $urandom_range(1, 45);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stalls in runs of random length when idling is on
  always @(negedge clk_i) begin
    if (!idling_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left == 0) begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_left  <= $urandom_range(1, 24);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin : watch_transfers
    poll_t  p;
    point_t exp_pt;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      p.pen = pen_down_i;
      p.wx  = raw_x_word_i;
      p.wy  = raw_y_word_i;
      due_points.push_back(predict_poll(p));
      polls_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_points.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d pressed=%0b",
                 $time, point_x_o, point_y_o, pressed_o);
        errors++;
      end else begin
        exp_pt = due_points.pop_front();
        points_checked++;
        if (point_x_o !== exp_pt.x) begin
          $display("%0t: point_x expected %0d got %0d", $time, exp_pt.x, point_x_o);
          errors++;
        end
        if (point_y_o !== exp_pt.y) begin
          $display("%0t: point_y expected %0d got %0d", $time, exp_pt.y, point_y_o);
          errors++;
        end
        if (pressed_o !== exp_pt.pressed) begin
          $display("%0t: pressed expected %0b got %0b", $time, exp_pt.pressed, pressed_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_points.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SmpW-1:0] xlo;
    logic [SmpW-1:0] xhi;
    logic [SmpW-1:0] ylo;
    logic [SmpW-1:0] yhi;
    logic [SmpW-1:0] sx;
    logic [SmpW-1:0] sy;
    cal_reg[tsc_pkg::REG_X_MIN] = tsc_pkg::MinReset;
    cal_reg[tsc_pkg::REG_X_MAX] = tsc_pkg::MaxReset;
    cal_reg[tsc_pkg::REG_Y_MIN] = tsc_pkg::MinReset;
    cal_reg[tsc_pkg::REG_Y_MAX] = tsc_pkg::MaxReset;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed polls against the reset calibration, no idling
    push_poll(1'b0, 16'h1234, 16'hFEDC);                  // pen up straight after reset
    push_poll(1'b1, 16'h0000, 16'h0000);                  // sample zero, below min
    push_poll(1'b1, 16'hFFFF, 16'hFFFF);                  // full scale, beyond max
    push_poll(1'b0, 16'h0000, 16'h0000);
    push_poll(1'b1, {1'b0, 12'd200, 3'b000}, {1'b1, 12'd200, 3'b111});   // at min
    push_poll(1'b1, {1'b0, 12'd201, 3'b000}, {1'b0, 12'd199, 3'b000});
    push_poll(1'b1, {1'b0, 12'd3800, 3'b000}, {1'b1, 12'd3800, 3'b101}); // at max
    push_poll(1'b1, {1'b0, 12'd3799, 3'b010}, {1'b0, 12'd3801, 3'b000});
    push_poll(1'b1, {1'b0, 12'd2000, 3'b000}, {1'b0, 12'd1000, 3'b000});
    push_poll(1'b1, {1'b1, 12'd2000, 3'b111}, {1'b1, 12'd1000, 3'b111}); // junk bits only
    push_poll(1'b0, 16'hFFFF, 16'hFFFF);                  // held point comes back
    push_poll(1'b0, 16'h5555, 16'hAAAA);
    push_poll(1'b1, {1'b0, 12'hAAA, 3'b000}, {1'b0, 12'h555, 3'b000});
    push_poll(1'b1, {1'b0, 12'h555, 3'b000}, {1'b0, 12'hAAA, 3'b000});
    push_poll(1'b1, 16'h7FF8, 16'h0007);
    push_poll(1'b0, 16'h0000, 16'hFFFF);
    wait_drained();

    idling_on = 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          xlo = SmpW'(200);  xhi = SmpW'(3800); ylo = SmpW'(200);  yhi = SmpW'(3800);
        end
        1: begin
          xlo = SmpW'(0);    xhi = SmpW'(4095); ylo = SmpW'(0);    yhi = SmpW'(4095);
        end
        2: begin  // zero span
          xlo = SmpW'(2000); xhi = SmpW'(2000); ylo = SmpW'(4095); yhi = SmpW'(4095);
        end
        3: begin  // inverted span
          xlo = SmpW'(4095); xhi = SmpW'(0);    ylo = SmpW'(3000); yhi = SmpW'(100);
        end
        4: begin  // scale saturates
          xlo = SmpW'(100);  xhi = SmpW'(101);  ylo = SmpW'(0);    yhi = SmpW'(1);
        end
        default: begin
          xlo = SmpW'($urandom_range(0, 3000));
          xhi = SmpW'($urandom_range(xlo, 4095));
          ylo = SmpW'($urandom_range(0, 3000));
          yhi = SmpW'($urandom_range(ylo, 4095));
        end
      endcase
      set_calibration(xlo, xhi, ylo, yhi);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 9) < 6) begin
          sx = near_span(xlo, xhi);
          sy = near_span(ylo, yhi);
        end else begin
          sx = SmpW'($urandom);
          sy = SmpW'($urandom);
        end
        push_poll($urandom_range(0, 3) != 0, word_of(sx), word_of(sy));
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("Sent %0d polls over %0d calibration settings; %0d results checked.",
             polls_taken, NumPhases + 1, points_checked);
    $display("Covered zero, inverted and one-count spans plus full-scale and junk-bit samples.");
    if (errors == 0 && due_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
